/* src/plcl_pkg.sv */
// package for the piecewise-linear curve lookup
// holds the divider stage record, its step function and fixed widths; no dependencies
package plcl_pkg;

    // configuration index and field widths, and the output offset
    localparam int CFG_IDX_W   = 3;
    localparam int SAMPLE_W    = 32;
    localparam int KNOT_W      = 32;
    localparam int HALF_W      = 16;
    localparam int OUT_W       = 17;
    localparam int OUT_TDATA_W = 24;
    localparam int CURVE_OFFSET = 256;

    // divider steps done in one pipeline stage, and stage count
    localparam int DIV_STEPS_PER_ST = 2;
    localparam int DIV_ST = HALF_W / DIV_STEPS_PER_ST;

    // one item inside the restoring divider
    typedef struct packed {
        logic [HALF_W-1:0]        rem;    // partial remainder, always below den
        logic [HALF_W-1:0]        sh;     // dividend bits still to shift in, quotient bits in
        logic [HALF_W-1:0]        den;
        logic                     neg;
        logic signed [HALF_W-1:0] olo;
        logic                     halve;
    } t_div_st;

    // one restoring division step
    function automatic t_div_st div_step(input t_div_st d);
        t_div_st             r;
        logic [HALF_W:0]     t;
        logic                ge;
        r  = d;
        t  = {d.rem, d.sh[HALF_W-1]};
        ge = (t >= {1'b0, d.den});
        if (ge) begin
            r.rem = HALF_W'(t - {1'b0, d.den});
        end else begin
            r.rem = t[HALF_W-1:0];
        end
        r.sh = {d.sh[HALF_W-2:0], ge};
        return r;
    endfunction

endpackage

/* src/piecewise_linear_curve_lookup_top.sv */
// piecewise-linear curve lookup, top level
// clamp, segment search, product, restoring divider, optional halving and offset in one pipeline; uses plcl_pkg
//
// usage:
//   s_axis carries one sample per item: tdata = sample_value (32 bits, signed),
//   tuser = halve_flag. m_axis returns one mapped_value per item in tdata[16:0].
//   the cfg channel writes knot registers (index 0..NUM_KNOTS-1, breakpoint in
//   bits 31:16, output in bits 15:0); it is always ready, writes beyond the knot
//   count are dropped. write knots only while no item is in flight.
// throughput: one item per cycle unless m_axis stalls; the 16-bit quotient comes from an 8-stage
//   restoring divider doing two quotient bits per stage.
// reset: knots clear to zero and all stage valid bits clear.
// stall: each stage moves on when it is empty or the next one moves, so bubbles
//   fill up and input is refused only when every stage holds an item.
module piecewise_linear_curve_lookup_top
    import plcl_pkg::*;
#(
    parameter int NUM_KNOTS = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [KNOT_W-1:0]       i_cfg_data,
    // input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_W-1:0]     s_axis_tdata,   // [31:0] sample_value
    input  logic                    s_axis_tuser,   // [0] halve_flag
    // result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata    // [16:0] mapped_value, [23:17] zero
);

    localparam int NST    = 4 + DIV_ST + 2;
    localparam int ST_DIV = 4;
    localparam int ST_SUM = ST_DIV + DIV_ST;
    localparam int ST_OUT = ST_SUM + 1;

    logic [KNOT_W-1:0] r_knot [NUM_KNOTS];
    logic [NST-1:0]    r_v;
    logic [NST-1:0]    ce;

    // stage registers
    logic signed [HALF_W-1:0]   r1_x;
    logic                       r1_halve;
    logic signed [HALF_W:0]     r2_dx, r2_do;
    logic [HALF_W-1:0]          r2_den;
    logic signed [HALF_W-1:0]   r2_olo;
    logic                       r2_halve;
    logic signed [2*HALF_W+1:0] r3_prod;
    logic [HALF_W-1:0]          r3_den;
    logic signed [HALF_W-1:0]   r3_olo;
    logic                       r3_halve;
    t_div_st                    r_div [DIV_ST+1];
    logic signed [HALF_W+1:0]   r_sum;
    logic                       r_sum_halve;
    logic [OUT_W-1:0]           r_out;

    // next values
    logic signed [HALF_W-1:0]   n1_x;
    logic signed [HALF_W:0]     n2_dx, n2_do;
    logic [HALF_W-1:0]          n2_den;
    logic signed [HALF_W-1:0]   n2_olo;
    t_div_st                    n4_div;
    t_div_st                    n_div [DIV_ST];
    logic signed [HALF_W+1:0]   n_sum;
    logic [OUT_W-1:0]           n_out;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KNOTS; k++) r_knot[k] <= '0;
        end else if (i_cfg_valid) begin
            for (int k = 0; k < NUM_KNOTS; k++) begin
                if (i_cfg_index == CFG_IDX_W'(k)) r_knot[k] <= i_cfg_data;
            end
        end
    end

    // stage advance chain
    always_comb begin
        ce[NST-1] = !r_v[NST-1] || m_axis_tready;
        for (int k = NST-2; k >= 0; k--) ce[k] = !r_v[k] || ce[k+1];
    end

    assign s_axis_tready = ce[0];
    assign m_axis_tvalid = r_v[NST-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ce[0]) r_v[0] <= s_axis_tvalid;
            for (int k = 1; k < NST; k++) begin
                if (ce[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: clamp into the knot span
    always_comb begin
        logic signed [HALF_W-1:0]   top, bot;
        logic signed [SAMPLE_W-1:0] x;
        top = $signed(r_knot[0][KNOT_W-1:HALF_W]);
        bot = $signed(r_knot[NUM_KNOTS-1][KNOT_W-1:HALF_W]);
        x   = $signed(s_axis_tdata);
        if (x > SAMPLE_W'(top)) begin
            n1_x = top;
        end else if (x < SAMPLE_W'(bot)) begin
            n1_x = bot;
        end else begin
            n1_x = x[HALF_W-1:0];
        end
    end

    // stage 1: segment search; direct outputs become a zero product
    always_comb begin
        logic signed [HALF_W-1:0] bh, bl, oh, ol, top;
        logic signed [HALF_W:0]   dd;
        top    = $signed(r_knot[0][KNOT_W-1:HALF_W]);
        dd     = '0;
        n2_dx  = '0;
        n2_do  = '0;
        n2_den = HALF_W'(1);
        n2_olo = $signed(r_knot[NUM_KNOTS-1][HALF_W-1:0]);
        for (int i = NUM_KNOTS-1; i >= 1; i--) begin
            bh = $signed(r_knot[i-1][KNOT_W-1:HALF_W]);
            bl = $signed(r_knot[i][KNOT_W-1:HALF_W]);
            oh = $signed(r_knot[i-1][HALF_W-1:0]);
            ol = $signed(r_knot[i][HALF_W-1:0]);
            if (!(r1_x <= bl)) begin
                n2_dx  = (HALF_W+1)'(r1_x) - (HALF_W+1)'(bl);
                n2_do  = (HALF_W+1)'(oh) - (HALF_W+1)'(ol);
                dd     = (HALF_W+1)'(bh) - (HALF_W+1)'(bl);
                n2_den = dd[HALF_W-1:0];
                n2_olo = ol;
            end
        end
        if (r1_x > top) begin
            n2_dx  = '0;
            n2_do  = '0;
            n2_den = HALF_W'(1);
            n2_olo = $signed(r_knot[0][HALF_W-1:0]);
        end
    end

    // stage 3: magnitude and divider load
    always_comb begin
        logic signed [2*HALF_W+1:0] mag;
        mag           = r3_prod[2*HALF_W+1] ? -r3_prod : r3_prod;
        n4_div.rem    = mag[2*HALF_W-1:HALF_W];
        n4_div.sh     = mag[HALF_W-1:0];
        n4_div.den    = r3_den;
        n4_div.neg    = r3_prod[2*HALF_W+1];
        n4_div.olo    = r3_olo;
        n4_div.halve  = r3_halve;
    end

    // divider stages, two steps each
    always_comb begin
        for (int s = 0; s < DIV_ST; s++) begin
            n_div[s] = r_div[s];
            for (int j = 0; j < DIV_STEPS_PER_ST; j++) n_div[s] = div_step(n_div[s]);
        end
    end

    // sign the quotient and add the lower knot output
    always_comb begin
        logic signed [HALF_W:0] q;
        q = r_div[DIV_ST].neg ? -$signed({1'b0, r_div[DIV_ST].sh})
                              :  $signed({1'b0, r_div[DIV_ST].sh});
        n_sum = (HALF_W+2)'(q) + (HALF_W+2)'(r_div[DIV_ST].olo);
    end

    // optional halving toward zero, then offset
    always_comb begin
        logic signed [HALF_W+1:0] adj, h, o;
        adj   = r_sum + (HALF_W+2)'(r_sum_halve & r_sum[HALF_W+1]);
        h     = r_sum_halve ? (adj >>> 1) : r_sum;
        o     = h + (HALF_W+2)'(CURVE_OFFSET);
        n_out = o[OUT_W-1:0];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ce[0]) begin
            r1_x     <= n1_x;
            r1_halve <= s_axis_tuser;
        end
        if (ce[1]) begin
            r2_dx    <= n2_dx;
            r2_do    <= n2_do;
            r2_den   <= n2_den;
            r2_olo   <= n2_olo;
            r2_halve <= r1_halve;
        end
        if (ce[2]) begin
            r3_prod  <= r2_dx * r2_do;
            r3_den   <= r2_den;
            r3_olo   <= r2_olo;
            r3_halve <= r2_halve;
        end
        if (ce[3]) r_div[0] <= n4_div;
        for (int s = 0; s < DIV_ST; s++) begin
            if (ce[ST_DIV+s]) r_div[s+1] <= n_div[s];
        end
        if (ce[ST_SUM]) begin
            r_sum       <= n_sum;
            r_sum_halve <= r_div[DIV_ST].halve;
        end
        if (ce[ST_OUT]) r_out <= n_out;
    end

    // input is refused only with every stage full
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> ($countones(r_v) == NST))
        else $error("input refused with a free stage");

    // divider remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_SUM-1] |-> (r_div[DIV_ST].rem < r_div[DIV_ST].den))
        else $error("divider remainder out of range");

    // a stalled result moves only when taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

/* tb/sv/testbench.sv */
// testbench for the piecewise-linear curve lookup
// drives samples and knot writes, predicts each mapped value and checks it; uses plcl_pkg
module testbench
    import plcl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKNOTS    = 5;
    localparam int WD_LIMIT  = 4000;
    localparam int HOLD_LEN  = 300;
    localparam int TAIL_WAIT = 40;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                halve;
    } t_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [KNOT_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    in_data = '0;
    logic                   in_user = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] out_data;

    t_sample           pending_samples[$];
    logic [OUT_W-1:0]  expected_mapped[$];
    logic [KNOT_W-1:0] knot_copy[NKNOTS];
    logic              no_idle = 1'b0;
    logic              hold_req = 1'b0;
    int                mismatches = 0;
    int                n_in = 0;
    int                n_out = 0;
    int                n_halved = 0;
    int                n_settings = 0;
    int                quiet_cycles = 0;

    piecewise_linear_curve_lookup_top #(.NUM_KNOTS(NKNOTS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),   // [31:0] sample_value
        .s_axis_tuser  (in_user),   // [0] halve_flag
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)   // [16:0] mapped_value, [23:17] zero
    );

    always #1 i_clk = ~i_clk;

    function automatic longint knot_bp(int k);
        return longint'($signed(knot_copy[k][31:16]));
    endfunction

    function automatic longint knot_out(int k);
        return longint'($signed(knot_copy[k][15:0]));
    endfunction

    // clamp, segment search, interpolate, halve, offset
    function automatic logic [OUT_W-1:0] predict_mapped(t_sample s);
        longint x, top, bottom, res, den;
        int     i;
        x      = longint'($signed(s.sample));
        top    = knot_bp(0);
        bottom = knot_bp(NKNOTS-1);
        if (x > top) x = top;
        else if (x < bottom) x = bottom;
        if (x > top) begin
            res = knot_out(0);
        end else begin
            i = 1;
            while (i < NKNOTS && x <= knot_bp(i)) i++;
            if (i >= NKNOTS) begin
                res = knot_out(NKNOTS-1);
            end else begin
                den = knot_bp(i-1) - knot_bp(i);
                if (den == 0) res = knot_out(i);
                else res = ((x - knot_bp(i)) * (knot_out(i-1) - knot_out(i))) / den
                           + knot_out(i);
            end
        end
        if (s.halve) res = res / 2;
        res = res + CURVE_OFFSET;
        return res[OUT_W-1:0];
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (in_valid && in_ready) begin
            expected_mapped.push_back(predict_mapped({in_data, in_user}));
            n_in++;
            if (in_user) n_halved++;
        end
        if (!in_valid || in_ready) begin
            if (pending_samples.size() > 0 && (no_idle || $urandom_range(99) >= 19)) begin
                t_sample s;
                s = pending_samples.pop_front();
                in_valid <= 1'b1;
                in_data  <= s.sample;
                in_user  <= s.halve;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random and long back-pressure
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (out_valid && out_ready) begin
            n_out++;
            if (expected_mapped.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", out_data);
            end else begin
                logic [OUT_W-1:0] exp_v;
                exp_v = expected_mapped.pop_front();
                if (out_data !== {{(OUT_TDATA_W-OUT_W){1'b0}}, exp_v}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mapped_value mismatch: expected %h actual %h",
                                 exp_v, out_data);
                end
            end
        end
        if (hold_req && hold_cnt < HOLD_LEN) begin
            hold_cnt  <= hold_cnt + 1;
            out_ready <= 1'b0;
        end else begin
            if (!hold_req) hold_cnt <= 0;
            out_ready <= i_rst_n && (no_idle || $urandom_range(99) >= 19);
        end
    end

    // watchdog on cycles with no accepted item or write
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog: no progress, %0d results still expected",
                     expected_mapped.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_knot(input int idx, input logic [KNOT_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= value;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx < NKNOTS) knot_copy[idx] = value;
    endtask

    // checked between edges so the driver's updates have settled
    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_valid || expected_mapped.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic load_curve(input logic [15:0] bp[NKNOTS], input logic [15:0] ov[NKNOTS]);
        for (int k = 0; k < NKNOTS; k++) write_knot(k, {bp[k], ov[k]});
        n_settings++;
    endtask

    task automatic push_sample(input logic [31:0] v, input logic h);
        pending_samples.push_back({v, h});
    endtask

    // directed points around every breakpoint plus the sample extremes
    task automatic push_directed();
        for (int h = 0; h < 2; h++) begin
            push_sample(32'h7fff_ffff, h[0]);
            push_sample(32'h8000_0000, h[0]);
            push_sample(32'h0, h[0]);
        end
        for (int k = 0; k < NKNOTS; k++) begin
            push_sample(32'(knot_bp(k)), k[0]);
            push_sample(32'(knot_bp(k) + 1), ~k[0]);
            push_sample(32'(knot_bp(k) - 1), k[0]);
        end
    endtask

    // mostly values near the knot span, some over the full range
    task automatic push_random(input int count);
        logic [31:0] v;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) v = $urandom;
            else v = 32'($signed($urandom_range(80000)) - 40000);
            push_sample(v, 1'($urandom_range(1)));
        end
    endtask

    task automatic random_descending(output logic [15:0] bp[NKNOTS],
                                     output logic [15:0] ov[NKNOTS]);
        int b;
        b = $urandom_range(65535) - 32768;
        if (b < -32768 + 4 * 200) b = -32768 + 4 * 200;
        for (int k = 0; k < NKNOTS; k++) begin
            bp[k] = 16'(b);
            ov[k] = 16'($urandom);
            b = b - 1 - $urandom_range(199);
        end
    endtask

    initial begin
        logic [15:0] bp[NKNOTS];
        logic [15:0] ov[NKNOTS];
        for (int k = 0; k < NKNOTS; k++) knot_copy[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset knots: every sample maps to CURVE_OFFSET alone
        push_directed();
        wait_drained();

        // full-scale descending curve with extreme outputs
        bp = '{16'h7fff, 16'h4000, 16'h0000, 16'hc000, 16'h8000};
        ov = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
        load_curve(bp, ov);
        write_knot(7, $urandom);    // beyond knot count, dropped
        push_directed();
        no_idle = 1'b1;
        push_random(100);
        wait_drained();
        no_idle = 1'b0;

        // long receiver hold while the sender keeps offering
        random_descending(bp, ov);
        load_curve(bp, ov);
        push_directed();
        hold_req = 1'b1;
        push_random(150);
        repeat (HOLD_LEN + 10) @(posedge i_clk);
        hold_req = 1'b0;
        wait_drained();

        // out-of-order breakpoints
        for (int k = 0; k < NKNOTS; k++) begin
            bp[k] = 16'($urandom);
            ov[k] = 16'($urandom);
        end
        load_curve(bp, ov);
        push_directed();
        push_random(120);
        wait_drained();

        // equal neighboring breakpoints
        random_descending(bp, ov);
        bp[2] = bp[1];
        bp[4] = bp[3];
        load_curve(bp, ov);
        push_directed();
        push_random(120);
        wait_drained();

        // inverted extremes, then a few more random curves
        bp = '{16'h7fff, 16'h7ffe, 16'h8001, 16'h8001, 16'h8000};
        ov = '{16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        load_curve(bp, ov);
        push_directed();
        push_random(60);
        wait_drained();
        for (int r = 0; r < 3; r++) begin
            random_descending(bp, ov);
            load_curve(bp, ov);
            push_random(30);
            wait_drained();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (expected_mapped.size() != 0) mismatches++;
        $display("ran %0d samples (%0d halved) over %0d knot settings, %0d results checked",
                 n_in, n_halved, n_settings, n_out);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
